@@ hdl/mhmd_pkg.sv @@
// shared types and constants of the hi/lo multiply/divide unit
`default_nettype none

package mhmd_pkg;

    localparam int DATA_W      = 64;
    localparam int HALF_W      = DATA_W / 2;
    localparam int OP_W        = 4;
    localparam int SUM_W       = DATA_W + 2;
    localparam int WORD_STEPS  = HALF_W;
    localparam int DWORD_STEPS = DATA_W;
    localparam int CNT_W       = $clog2(DWORD_STEPS);

    typedef logic [DATA_W-1:0] data_t;

    typedef enum logic [OP_W-1:0] {
        OP_MULT      = 4'd0,
        OP_MULT_UNS  = 4'd1,
        OP_DIV       = 4'd2,
        OP_DIV_UNS   = 4'd3,
        OP_DMULT     = 4'd4,
        OP_DMULT_UNS = 4'd5,
        OP_DDIV      = 4'd6,
        OP_DDIV_UNS  = 4'd7,
        OP_MTHI      = 4'd8,
        OP_MTLO      = 4'd9,
        OP_MFHI      = 4'd10,
        OP_MFLO      = 4'd11
    } op_t;

    typedef enum logic [2:0] {
        STEP_HOLD    = 3'd0,
        STEP_LOAD    = 3'd1,
        STEP_NEG_SH  = 3'd2,
        STEP_NEG_Y   = 3'd3,
        STEP_NEG_ACC = 3'd4,
        STEP_ALIGN   = 3'd5,
        STEP_MUL     = 3'd6,
        STEP_DIV     = 3'd7
    } step_t;

endpackage

`default_nettype wire

@@ hdl/mhmd_iter_unit.sv @@
// shared adder with accumulator, shift and operand registers for shift-add and restoring divide
`default_nettype none

module mhmd_iter_unit (
    input  wire logic          aclk,
    input  wire mhmd_pkg::step_t step,
    input  wire mhmd_pkg::data_t load_a,
    input  wire mhmd_pkg::data_t load_b,
    output mhmd_pkg::data_t    acc_out,
    output mhmd_pkg::data_t    sh_out
);
    import mhmd_pkg::*;

    data_t            acc_reg, acc_next;
    data_t            sh_reg, sh_next;
    data_t            y_reg, y_next;
    logic [SUM_W-1:0] add_x, add_y, sum;
    logic             add_inv;
    logic             ge;

    // adder operand select
    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_inv = 1'b0;
        case (step)
            STEP_NEG_SH: begin
                add_y   = {2'b00, sh_reg};
                add_inv = 1'b1;
            end
            STEP_NEG_Y: begin
                add_y   = {2'b00, y_reg};
                add_inv = 1'b1;
            end
            STEP_NEG_ACC: begin
                add_y   = {2'b00, acc_reg};
                add_inv = 1'b1;
            end
            STEP_MUL: begin
                add_x = {2'b00, acc_reg[DATA_W-2:0], 1'b0};
                add_y = sh_reg[DATA_W-1] ? {2'b00, y_reg} : '0;
            end
            STEP_DIV: begin
                add_x   = {1'b0, acc_reg, sh_reg[DATA_W-1]};
                add_y   = {2'b00, y_reg};
                add_inv = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign sum = add_x + (add_y ^ {SUM_W{add_inv}}) + {{(SUM_W-1){1'b0}}, add_inv};
    assign ge  = ~sum[SUM_W-1];

    always_comb begin
        acc_next = acc_reg;
        sh_next  = sh_reg;
        y_next   = y_reg;
        case (step)
            STEP_LOAD: begin
                acc_next = '0;
                sh_next  = load_a;
                y_next   = load_b;
            end
            STEP_NEG_SH:  sh_next  = sum[DATA_W-1:0];
            STEP_NEG_Y:   y_next   = sum[DATA_W-1:0];
            STEP_NEG_ACC: acc_next = sum[DATA_W-1:0];
            STEP_ALIGN:   sh_next  = {sh_reg[HALF_W-1:0], {HALF_W{1'b0}}};
            STEP_MUL: begin
                acc_next = sum[DATA_W-1:0];
                sh_next  = {sh_reg[DATA_W-2:0], 1'b0};
            end
            STEP_DIV: begin
                acc_next = ge ? sum[DATA_W-1:0] : {acc_reg[DATA_W-2:0], sh_reg[DATA_W-1]};
                sh_next  = {sh_reg[DATA_W-2:0], ge};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        y_reg   <= y_next;
    end

    assign acc_out = acc_reg;
    assign sh_out  = sh_reg;

endmodule

`default_nettype wire

@@ hdl/mips_hilo_multiply_divide_unit.sv @@
// top level: sequencer, hi/lo registers and result word register
//
//  channel  ports                                              direction
//  s_       s_valid s_ready s_opcode s_operand_a s_operand_b   in
//  m_       m_valid m_ready m_read_value m_hi_now m_lo_now
//           m_divide_by_zero                                   out
//
// word and doubleword multiply/divide: one radix-2 step per cycle through the
// shared adder for each bit of the word or doubleword, plus sign and align steps.
// moves, unused codes and zero divisors go from idle straight to the finish state.
// s_ready is high only while the sequencer is idle; a held result stalls the
// next word in its final step. aresetn clears hi, lo and the sequencer.
`default_nettype none

module mips_hilo_multiply_divide_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [mhmd_pkg::OP_W-1:0]     s_opcode,
    input  wire logic [mhmd_pkg::DATA_W-1:0]   s_operand_a,
    input  wire logic [mhmd_pkg::DATA_W-1:0]   s_operand_b,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [mhmd_pkg::DATA_W-1:0]        m_read_value,
    output logic [mhmd_pkg::DATA_W-1:0]        m_hi_now,
    output logic [mhmd_pkg::DATA_W-1:0]        m_lo_now,
    output logic                               m_divide_by_zero
);
    import mhmd_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_NEG_A  = 8'b0000_0010,
        S_NEG_B  = 8'b0000_0100,
        S_ALIGN  = 8'b0000_1000,
        S_RUN    = 8'b0001_0000,
        S_FIX_Q  = 8'b0010_0000,
        S_FIX_R  = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    op_t              op_reg;
    logic             word_reg, is_div_reg, neg_a_reg, neg_b_reg, dz_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    data_t            hi_reg, hi_next, lo_reg, lo_next, read_next;
    logic             m_valid_reg;
    data_t            m_read_value_reg, m_hi_now_reg, m_lo_now_reg;
    logic             m_dz_reg;

    op_t   in_op;
    logic  in_word, in_mul, in_div, in_sgn, in_na, in_nb, in_bz, in_dz;
    data_t in_a, in_b;
    logic  accept, fire;
    step_t step;
    data_t acc, sh;

    assign in_op = op_t'(s_opcode);

    // decode of the incoming word
    always_comb begin
        in_word = in_op inside {OP_MULT, OP_MULT_UNS, OP_DIV, OP_DIV_UNS};
        in_mul  = in_op inside {OP_MULT, OP_MULT_UNS, OP_DMULT, OP_DMULT_UNS};
        in_div  = in_op inside {OP_DIV, OP_DIV_UNS, OP_DDIV, OP_DDIV_UNS};
        in_sgn  = in_op inside {OP_MULT, OP_DIV, OP_DDIV};
        if (in_word) begin
            in_a  = {{HALF_W{in_sgn & s_operand_a[HALF_W-1]}}, s_operand_a[HALF_W-1:0]};
            in_b  = {{HALF_W{in_sgn & s_operand_b[HALF_W-1]}}, s_operand_b[HALF_W-1:0]};
            in_bz = (s_operand_b[HALF_W-1:0] == '0);
        end else begin
            in_a  = s_operand_a;
            in_b  = s_operand_b;
            in_bz = (s_operand_b == '0);
        end
        in_na = in_sgn & in_a[DATA_W-1];
        in_nb = in_sgn & in_b[DATA_W-1];
        in_dz = in_div & in_bz;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid & s_ready;
    assign fire    = (state_reg == S_FINISH) & (~m_valid_reg | m_ready);

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        step       = STEP_HOLD;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    step       = STEP_LOAD;
                    state_next = ((in_mul | in_div) & ~in_dz) ? S_NEG_A : S_FINISH;
                end
            end
            S_NEG_A: begin
                if (neg_a_reg) begin
                    step = STEP_NEG_SH;
                end
                state_next = S_NEG_B;
            end
            S_NEG_B: begin
                if (neg_b_reg) begin
                    step = STEP_NEG_Y;
                end
                state_next = S_ALIGN;
            end
            S_ALIGN: begin
                if (word_reg) begin
                    step     = STEP_ALIGN;
                    cnt_next = CNT_W'(WORD_STEPS - 1);
                end else begin
                    cnt_next = CNT_W'(DWORD_STEPS - 1);
                end
                state_next = S_RUN;
            end
            S_RUN: begin
                step     = is_div_reg ? STEP_DIV : STEP_MUL;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = S_FIX_Q;
                end
            end
            S_FIX_Q: begin
                if (neg_a_reg ^ neg_b_reg) begin
                    step = is_div_reg ? STEP_NEG_SH : STEP_NEG_ACC;
                end
                state_next = S_FIX_R;
            end
            S_FIX_R: begin
                if (is_div_reg & neg_a_reg) begin
                    step = STEP_NEG_ACC;
                end
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (fire) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    mhmd_iter_unit u_iter (
        .aclk    (aclk),
        .step    (step),
        .load_a  (in_a),
        .load_b  (in_b),
        .acc_out (acc),
        .sh_out  (sh)
    );

    // hi/lo update at the end of an operation
    always_comb begin
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        read_next = '0;
        case (op_reg)
            OP_MULT, OP_MULT_UNS: begin
                hi_next[HALF_W-1:0] = acc[DATA_W-1:HALF_W];
                lo_next[HALF_W-1:0] = acc[HALF_W-1:0];
            end
            OP_DIV, OP_DIV_UNS: begin
                hi_next[HALF_W-1:0] = dz_reg ? '0 : acc[HALF_W-1:0];
                lo_next[HALF_W-1:0] = dz_reg ? '0 : sh[HALF_W-1:0];
            end
            OP_DMULT, OP_DMULT_UNS: begin
                hi_next = '0;
                lo_next = acc;
            end
            OP_DDIV, OP_DDIV_UNS: begin
                hi_next = dz_reg ? '0 : acc;
                lo_next = dz_reg ? '0 : sh;
            end
            OP_MTHI: hi_next = sh;
            OP_MTLO: lo_next = sh;
            OP_MFHI: read_next = hi_reg;
            OP_MFLO: read_next = lo_reg;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            hi_reg      <= '0;
            lo_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (fire) begin
                m_valid_reg <= 1'b1;
                hi_reg      <= hi_next;
                lo_reg      <= lo_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        if (accept) begin
            op_reg     <= in_op;
            word_reg   <= in_word;
            is_div_reg <= in_div;
            neg_a_reg  <= in_na;
            neg_b_reg  <= in_nb;
            dz_reg     <= in_dz;
        end
        if (fire) begin
            m_read_value_reg <= read_next;
            m_hi_now_reg     <= hi_next;
            m_lo_now_reg     <= lo_next;
            m_dz_reg         <= dz_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_read_value     = m_read_value_reg;
    assign m_hi_now         = m_hi_now_reg;
    assign m_lo_now         = m_lo_now_reg;
    assign m_divide_by_zero = m_dz_reg;

    // hi/lo frozen while a result word is held
    a_hilo_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> $stable(hi_reg) && $stable(lo_reg))
        else $error("hi/lo changed while result held");

    // a new result word carries the registers it was formed from
    a_result_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> (m_hi_now == hi_reg) && (m_lo_now == lo_reg))
        else $error("result word does not match hi/lo");

    // zero divisor never enters the iteration
    a_dz_no_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RUN) |-> !dz_reg)
        else $error("zero divisor reached iteration");

    // sequencer leaves idle on accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("still ready after accept");

endmodule

`default_nettype wire

@@ tb/sv/hilo_result_checker.sv @@
// hi/lo register predictor and result word checker for the multiply/divide unit
module hilo_result_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [mhmd_pkg::OP_W-1:0]   s_opcode,
    input  logic [mhmd_pkg::DATA_W-1:0] s_operand_a,
    input  logic [mhmd_pkg::DATA_W-1:0] s_operand_b,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [mhmd_pkg::DATA_W-1:0] m_read_value,
    input  logic [mhmd_pkg::DATA_W-1:0] m_hi_now,
    input  logic [mhmd_pkg::DATA_W-1:0] m_lo_now,
    input  logic                        m_divide_by_zero,
    output int                          fail_count,
    output int                          pending,
    output int                          checked
);
    import mhmd_pkg::*;

    typedef struct packed {
        data_t read_value;
        data_t hi;
        data_t lo;
        logic  dz;
    } hilo_word_t;

    data_t      hi_reg;
    data_t      lo_reg;
    hilo_word_t expected_q[$];

    // truncating signed divide at 32 or 64 bits, divisor nonzero
    function automatic void divide_signed(input data_t a, input data_t b, input int width,
                                          output data_t q, output data_t r);
        data_t mask;
        data_t ma;
        data_t mb;
        logic  na;
        logic  nb;
        mask = (width == HALF_W) ? {{HALF_W{1'b0}}, {HALF_W{1'b1}}} : '1;
        na = a[width-1];
        nb = b[width-1];
        ma = (na ? -a : a) & mask;
        mb = (nb ? -b : b) & mask;
        q = ma / mb;
        r = ma % mb;
        if (na != nb) q = -q;
        if (na) r = -r;
        q = q & mask;
        r = r & mask;
    endfunction

    function automatic hilo_word_t hilo_step(logic [OP_W-1:0] op, data_t a, data_t b);
        hilo_word_t w;
        data_t      p;
        data_t      q;
        data_t      r;
        w = '0;
        case (op)
            OP_MULT: begin
                p = {{HALF_W{a[HALF_W-1]}}, a[HALF_W-1:0]}
                    * {{HALF_W{b[HALF_W-1]}}, b[HALF_W-1:0]};
                hi_reg[HALF_W-1:0] = p[DATA_W-1:HALF_W];
                lo_reg[HALF_W-1:0] = p[HALF_W-1:0];
            end
            OP_MULT_UNS: begin
                p = {{HALF_W{1'b0}}, a[HALF_W-1:0]} * {{HALF_W{1'b0}}, b[HALF_W-1:0]};
                hi_reg[HALF_W-1:0] = p[DATA_W-1:HALF_W];
                lo_reg[HALF_W-1:0] = p[HALF_W-1:0];
            end
            OP_DIV, OP_DIV_UNS: begin
                if (b[HALF_W-1:0] == '0) begin
                    w.dz = 1'b1;
                    hi_reg[HALF_W-1:0] = '0;
                    lo_reg[HALF_W-1:0] = '0;
                end else begin
                    if (op == OP_DIV) begin
                        divide_signed({{HALF_W{1'b0}}, a[HALF_W-1:0]},
                                      {{HALF_W{1'b0}}, b[HALF_W-1:0]}, HALF_W, q, r);
                    end else begin
                        q = {{HALF_W{1'b0}}, a[HALF_W-1:0]} / {{HALF_W{1'b0}}, b[HALF_W-1:0]};
                        r = {{HALF_W{1'b0}}, a[HALF_W-1:0]} % {{HALF_W{1'b0}}, b[HALF_W-1:0]};
                    end
                    hi_reg[HALF_W-1:0] = r[HALF_W-1:0];
                    lo_reg[HALF_W-1:0] = q[HALF_W-1:0];
                end
            end
            OP_DMULT, OP_DMULT_UNS: begin
                lo_reg = a * b;
                hi_reg = '0;
            end
            OP_DDIV, OP_DDIV_UNS: begin
                if (b == '0) begin
                    w.dz = 1'b1;
                    hi_reg = '0;
                    lo_reg = '0;
                end else begin
                    if (op == OP_DDIV) begin
                        divide_signed(a, b, DATA_W, q, r);
                    end else begin
                        q = a / b;
                        r = a % b;
                    end
                    hi_reg = r;
                    lo_reg = q;
                end
            end
            OP_MTHI: hi_reg = a;
            OP_MTLO: lo_reg = a;
            OP_MFHI: w.read_value = hi_reg;
            OP_MFLO: w.read_value = lo_reg;
            default: ;
        endcase
        w.hi = hi_reg;
        w.lo = lo_reg;
        return w;
    endfunction

    function automatic int field_mismatch(string name, data_t exp_v, data_t act_v);
        if (exp_v === act_v) return 0;
        $error("%s: expected %h, got %h", name, exp_v, act_v);
        return 1;
    endfunction

    always @(posedge aclk) begin : watch
        int         bad;
        hilo_word_t want;
        if (!aresetn) begin
            hi_reg = '0;
            lo_reg = '0;
            expected_q.delete();
            pending <= 0;
            fail_count <= 0;
            checked <= 0;
        end else begin
            bad = 0;
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result word with nothing expected: hi %h lo %h", m_hi_now, m_lo_now);
                    bad = 1;
                end else begin
                    want = expected_q.pop_front();
                    bad += field_mismatch("read_value", want.read_value, m_read_value);
                    bad += field_mismatch("hi_now", want.hi, m_hi_now);
                    bad += field_mismatch("lo_now", want.lo, m_lo_now);
                    bad += field_mismatch("divide_by_zero", data_t'(want.dz),
                                          data_t'(m_divide_by_zero));
                end
                checked <= checked + 1;
            end
            if (s_valid && s_ready)
                expected_q.push_back(hilo_step(s_opcode, s_operand_a, s_operand_b));
            pending <= expected_q.size();
            fail_count <= fail_count + bad;
        end
    end

endmodule

@@ tb/sv/tb_mips_hilo_multiply_divide_unit.sv @@
// stimulus, flow control and verdict for the hi/lo multiply/divide unit
module tb_mips_hilo_multiply_divide_unit;
    import mhmd_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 4'd12;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 4'd15;
    localparam int RESET_CYCLES   = 12;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int END_WAIT       = 80;
    localparam int PHASE_WORDS    = 470;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_opcode = '0;
    data_t               s_operand_a = '0;
    data_t               s_operand_b = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    data_t               m_read_value;
    data_t               m_hi_now;
    data_t               m_lo_now;
    logic                m_divide_by_zero;

    int fail_count;
    int pending;
    int checked;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_reqs = 0;
    int holds_done = 0;
    int idle_run = 0;
    int n_mul = 0;
    int n_div = 0;
    int n_div_zero = 0;
    int n_move = 0;
    int n_unused = 0;

    always #1 aclk = ~aclk;

    mips_hilo_multiply_divide_unit i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_operand_a      (s_operand_a),
        .s_operand_b      (s_operand_b),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_read_value     (m_read_value),
        .m_hi_now         (m_hi_now),
        .m_lo_now         (m_lo_now),
        .m_divide_by_zero (m_divide_by_zero)
    );

    hilo_result_checker i_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_operand_a      (s_operand_a),
        .s_operand_b      (s_operand_b),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_read_value     (m_read_value),
        .m_hi_now         (m_hi_now),
        .m_lo_now         (m_lo_now),
        .m_divide_by_zero (m_divide_by_zero),
        .fail_count       (fail_count),
        .pending          (pending),
        .checked          (checked)
    );

    // result side: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (holds_done != hold_reqs) begin
                holds_done++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_run <= 0;
        end else if (idle_run >= WATCHDOG_LIMIT) begin
            $display("mips_hilo_multiply_divide_unit verification failed");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    task automatic send_word(input logic [OP_W-1:0] op, input data_t a, input data_t b);
        s_valid <= 1'b1;
        s_opcode <= op;
        s_operand_a <= a;
        s_operand_b <= b;
        do @(posedge aclk); while (!s_ready);
        case (op)
            OP_MULT, OP_MULT_UNS, OP_DMULT, OP_DMULT_UNS: n_mul++;
            OP_DIV, OP_DIV_UNS: begin
                n_div++;
                if (b[HALF_W-1:0] == '0) n_div_zero++;
            end
            OP_DDIV, OP_DDIV_UNS: begin
                n_div++;
                if (b == '0) n_div_zero++;
            end
            OP_MTHI, OP_MTLO, OP_MFHI, OP_MFLO: n_move++;
            default: n_unused++;
        endcase
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    function automatic data_t rand_operand();
        data_t v;
        case ($urandom_range(9))
            0: v = data_t'($urandom_range(16));
            1: begin
                v = data_t'($urandom_range(16));
                v = -v;
            end
            2: begin
                case ($urandom_range(8))
                    0: v = '0;
                    1: v = 64'd1;
                    2: v = '1;
                    3: v = {1'b1, 63'b0};
                    4: v = {1'b0, {63{1'b1}}};
                    5: v = {{33{1'b1}}, 31'b0};
                    6: v = 64'h0000_0000_7FFF_FFFF;
                    7: v = {32'($urandom), 32'h8000_0000};
                    default: v = {32'($urandom), 32'hFFFF_FFFF};
                endcase
            end
            3: v = {32'($urandom), 32'b0};
            4: begin
                v[31:0] = $urandom;
                v[63:32] = {32{v[31]}};
            end
            default: v = {32'($urandom), 32'($urandom)};
        endcase
        return v;
    endfunction

    task automatic run_random(input int n_words);
        int              done;
        logic [OP_W-1:0] op;
        done = 0;
        while (done < n_words) begin
            if ($urandom_range(99) < 30) begin
                // preload both registers, one word op, read both back
                send_word(OP_MTHI, rand_operand(), rand_operand());
                send_word(OP_MTLO, rand_operand(), rand_operand());
                op = OP_W'($urandom_range(OP_DIV_UNS, OP_MULT));
                send_word(op, rand_operand(), rand_operand());
                send_word(OP_MFHI, rand_operand(), rand_operand());
                send_word(OP_MFLO, rand_operand(), rand_operand());
                done += 5;
            end else if ($urandom_range(99) < 8) begin
                op = OP_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
                send_word(op, rand_operand(), rand_operand());
            end else begin
                op = OP_W'($urandom_range(OP_MFLO, OP_MULT));
                send_word(op, rand_operand(), rand_operand());
                done++;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(OP_MTHI, '1, '0);
        send_word(OP_MTLO, 64'h8000_0000_0000_0001, '0);
        send_word(OP_MULT, 64'h1234_5678_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(OP_MULT_UNS, '1, '1);
        send_word(OP_MFHI, '0, '0);
        send_word(OP_MFLO, '1, '1);
        send_word(OP_DIV, 64'h0000_0000_8000_0000, 64'h0000_0000_FFFF_FFFF);
        send_word(OP_DIV, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2);
        send_word(OP_DIV_UNS, 64'd12345, 64'hFFFF_FFFF_0000_0000);
        send_word(OP_DIV, '1, '0);
        send_word(OP_DMULT, '1, '1);
        send_word(OP_DMULT_UNS, '1, 64'd2);
        send_word(OP_DDIV, {1'b1, 63'b0}, '1);
        send_word(OP_DDIV, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2);
        send_word(OP_DDIV, 64'd7, 64'hFFFF_FFFF_FFFF_FFFE);
        send_word(OP_DDIV_UNS, '1, 64'd1);
        send_word(OP_DDIV_UNS, '1, '0);
        send_word(OP_DDIV, {1'b1, 63'b0}, '0);
        send_word(OP_MTHI, '0, '1);
        send_word(OP_MTLO, '1, '0);
        send_word(OP_DIV_UNS, 64'h0000_0000_FFFF_FFFF, 64'd1);
        send_word(OP_MFHI, '1, '1);
        send_word(OP_MFLO, '0, '0);
        send_word(OP_UNUSED_FIRST, '1, '1);
        send_word(OP_UNUSED_LAST, '1, '0);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 0;
                    sink_stall_pct <= 0;
                end
                1: begin
                    src_idle_pct = 74;
                    sink_stall_pct <= 0;
                end
                2: begin
                    src_idle_pct = 0;
                    sink_stall_pct <= 74;
                end
                default: begin
                    src_idle_pct = 29;
                    sink_stall_pct <= 29;
                end
            endcase
            if (phase == 0) begin
                // long result back-pressure while words keep coming
                hold_reqs++;
                run_random(20);
                drain_results();
            end
            run_random(PHASE_WORDS);
            drain_results();
        end

        repeat (END_WAIT) @(posedge aclk);
        $display("covered %0d words: %0d multiply, %0d divide (%0d by zero), %0d move, %0d unused",
                 n_mul + n_div + n_move + n_unused, n_mul, n_div, n_div_zero, n_move, n_unused);
        $display("%0d result words checked, %0d mismatches", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("mips_hilo_multiply_divide_unit verification clean");
        else
            $display("mips_hilo_multiply_divide_unit verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/mhmd_pkg.sv
hdl/mhmd_iter_unit.sv
hdl/mips_hilo_multiply_divide_unit.sv
tb/sv/hilo_result_checker.sv
tb/sv/tb_mips_hilo_multiply_divide_unit.sv
